// File: rtl/json_string_unescape_assert.svh
// Assertion macros used by the RTL top level json_string_unescape.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// Same-cycle implication.
`define JSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// Next-cycle implication.
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

// File: rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  // Escape tracking: plain text, after a backslash, inside \u with 0..3 digits taken.
  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_ESC   = 3'd1,
    PH_HEX0  = 3'd2,
    PH_HEX1  = 3'd3,
    PH_HEX2  = 3'd4,
    PH_HEX3  = 3'd5
  } phase_e;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] BS_CODE   = 8'h08;
  localparam logic [7:0] FF_CODE   = 8'h0C;
  localparam logic [7:0] LF_CODE   = 8'h0A;
  localparam logic [7:0] CR_CODE   = 8'h0D;
  localparam logic [7:0] TAB_CODE  = 8'h09;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_open;
    logic       is_close;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       literal_end;
  } out_item_t;

  // Results caused by one request, low byte goes out first.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    is_end;
  } res_t;

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/jsu_if.sv
`default_nettype none

interface jsu_in_if;
  logic              valid;
  logic              ready;
  jsu_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jsu_out_if;
  logic               valid;
  logic               ready;
  jsu_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/jsu_decode.sv
`default_nettype none

module jsu_decode (
  input  jsu_pkg::phase_e   phase_i,
  input  logic [15:0]       accum_i,
  input  jsu_pkg::in_item_t item_i,
  output jsu_pkg::phase_e   phase_o,
  output logic [15:0]       accum_o,
  output jsu_pkg::res_t     res_o
);

  logic [15:0] cp;

  assign cp = {accum_i[11:0], jsu_pkg::hex_value(item_i.in_byte)};

  always_comb begin
    phase_o = phase_i;
    accum_o = accum_i;
    res_o   = '0;
    if (item_i.is_open) begin
      phase_o = jsu_pkg::PH_PLAIN;
      accum_o = '0;
    end else if (item_i.is_close) begin
      // drop any pending escape, emit the end marker
      phase_o      = jsu_pkg::PH_PLAIN;
      accum_o      = '0;
      res_o.cnt    = 2'd1;
      res_o.is_end = 1'b1;
    end else begin
      unique case (phase_i)
        jsu_pkg::PH_ESC: begin
          phase_o   = jsu_pkg::PH_PLAIN;
          res_o.cnt = 2'd1;
          case (item_i.in_byte) inside
            jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE, jsu_pkg::CH_APOS:
              res_o.bytes[0] = item_i.in_byte;
            jsu_pkg::CH_B: res_o.bytes[0] = jsu_pkg::BS_CODE;
            jsu_pkg::CH_F: res_o.bytes[0] = jsu_pkg::FF_CODE;
            jsu_pkg::CH_N: res_o.bytes[0] = jsu_pkg::LF_CODE;
            jsu_pkg::CH_R: res_o.bytes[0] = jsu_pkg::CR_CODE;
            jsu_pkg::CH_T: res_o.bytes[0] = jsu_pkg::TAB_CODE;
            jsu_pkg::CH_U: begin
              phase_o   = jsu_pkg::PH_HEX0;
              accum_o   = '0;
              res_o.cnt = 2'd0;
            end
            default: begin
              // unknown escape: pass the backslash and the byte through
              res_o.bytes[0] = jsu_pkg::CH_BSLASH;
              res_o.bytes[1] = item_i.in_byte;
              res_o.cnt      = 2'd2;
            end
          endcase
        end
        jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
          accum_o = cp;
          phase_o = jsu_pkg::phase_e'(phase_i + 3'd1);
        end
        jsu_pkg::PH_HEX3: begin
          phase_o = jsu_pkg::PH_PLAIN;
          accum_o = '0;
          if (cp[15:7] == 9'd0) begin
            res_o.bytes[0] = cp[7:0];
            res_o.cnt      = 2'd1;
          end else if (cp[15:11] == 5'd0) begin
            res_o.bytes[0] = {3'b110, cp[10:6]};
            res_o.bytes[1] = {2'b10, cp[5:0]};
            res_o.cnt      = 2'd2;
          end else begin
            res_o.bytes[0] = {4'b1110, cp[15:12]};
            res_o.bytes[1] = {2'b10, cp[11:6]};
            res_o.bytes[2] = {2'b10, cp[5:0]};
            res_o.cnt      = 2'd3;
          end
        end
        default: begin
          phase_o = jsu_pkg::PH_PLAIN;
          if (item_i.in_byte == jsu_pkg::CH_BSLASH) begin
            phase_o = jsu_pkg::PH_ESC;
          end else begin
            res_o.bytes[0] = item_i.in_byte;
            res_o.cnt      = 2'd1;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/json_string_unescape.sv
// Channel  Dir  Payload                                          Done when
// in_i     in   in_byte[7:0], is_open, is_close                  valid && ready
// out_o    out  out_byte[7:0], byte_valid, run_last, literal_end valid && ready
//
// A request enters the input register, is decoded from there and loads the
// result group register (up to three bytes) once the group is free.
// Results leave one per cycle while out_o is ready, through the single output
// port of the result group register, which thus limits the request rate.
// rst_ni clears the escape state, the input valid and the result count.
// An out_o stall holds the group; requests with results then back up.
`default_nettype none

`include "json_string_unescape_assert.svh"

module json_string_unescape (
  input  logic             clk_i,
  input  logic             rst_ni,
  jsu_in_if.sink           in_i,
  jsu_out_if.source        out_o
);

  // input register
  logic              in_vld_q;
  jsu_pkg::in_item_t in_q;

  // escape state
  jsu_pkg::phase_e   phase_q, phase_d;
  logic [15:0]       accum_q, accum_d;

  // result group register
  logic [jsu_pkg::MAX_RES-1:0][7:0] bytes_q;
  logic [1:0]        rem_q;
  logic [1:0]        idx_q;
  logic              end_q;

  jsu_pkg::res_t     res;
  logic              grp_free;
  logic              adv;
  logic              out_take;

  jsu_decode u_decode (
    .phase_i (phase_q),
    .accum_i (accum_q),
    .item_i  (in_q),
    .phase_o (phase_d),
    .accum_o (accum_d),
    .res_o   (res)
  );

  assign out_take = out_o.valid && out_o.ready;
  // group can take new results once its last one leaves
  assign grp_free = (rem_q == 2'd0) || (rem_q == 2'd1 && out_o.ready);
  // requests that cause no result advance regardless of the output side
  assign adv      = in_vld_q && ((res.cnt == 2'd0) || grp_free);

  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
  end

  // advance the escape state once per decoded request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_PLAIN;
      accum_q <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (adv && res.cnt != 2'd0) begin
      rem_q <= res.cnt;
      idx_q <= '0;
    end else if (out_take) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.cnt != 2'd0) begin
      bytes_q <= res.bytes;
      end_q   <= res.is_end;
    end
  end

  assign out_o.valid            = (rem_q != 2'd0);
  assign out_o.data.out_byte    = bytes_q[idx_q];
  assign out_o.data.byte_valid  = !end_q;
  assign out_o.data.run_last    = (rem_q == 2'd1);
  assign out_o.data.literal_end = end_q;

  // end marker is a lone, empty result
  `JSU_ASSERT_NOW(a_end_marker, out_o.valid && end_q, (rem_q == 2'd1) && (idx_q == 2'd0) && (bytes_q[0] == 8'h00))
  // decoded results show up on the output the next cycle
  `JSU_ASSERT_NEXT(a_load_shows, adv && res.cnt != 2'd0, out_o.valid)
  // a taken result that is not the last leaves more behind
  `JSU_ASSERT_NEXT(a_run_continues, out_take && !out_o.data.run_last, out_o.valid)
  // the group never runs past its three slots
  `JSU_ASSERT_NOW(a_slot_range, out_o.valid, ({1'b0, idx_q} + {1'b0, rem_q}) <= 3'd3)

endmodule

`default_nettype wire

// File: sim/unescape_checker.sv
`default_nettype none

module unescape_checker
  import jsu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if    in_mon,
  jsu_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  out_item_t   expected_q[$];
  phase_e      esc_phase;
  logic [15:0] code_acc;
  int          results_seen;

  // Non-hex characters count as zero.
  function automatic logic [3:0] digit_value(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic void queue_bytes(logic [2:0][7:0] seq, int n);
    for (int k = 0; k < n; k++) begin
      expected_q.push_back('{out_byte: seq[k], byte_valid: 1'b1,
                             run_last: (k == n - 1), literal_end: 1'b0});
    end
  endfunction

  function automatic void predict_request(in_item_t req);
    logic [2:0][7:0] seq;
    logic [15:0]     cp;
    int              n;
    seq = '0;
    cp  = '0;
    n   = 0;
    if (req.is_open) begin
      esc_phase = PH_PLAIN;
      code_acc  = '0;
      return;
    end
    if (req.is_close) begin
      esc_phase = PH_PLAIN;
      code_acc  = '0;
      expected_q.push_back('{out_byte: 8'h00, byte_valid: 1'b0,
                             run_last: 1'b1, literal_end: 1'b1});
      return;
    end
    if (esc_phase == PH_ESC) begin
      esc_phase = PH_PLAIN;
      case (req.in_byte)
        CH_BSLASH, CH_SLASH, CH_QUOTE, CH_APOS: begin
          seq[0] = req.in_byte;
          n = 1;
        end
        CH_B: begin
          seq[0] = BS_CODE;
          n = 1;
        end
        CH_F: begin
          seq[0] = FF_CODE;
          n = 1;
        end
        CH_N: begin
          seq[0] = LF_CODE;
          n = 1;
        end
        CH_R: begin
          seq[0] = CR_CODE;
          n = 1;
        end
        CH_T: begin
          seq[0] = TAB_CODE;
          n = 1;
        end
        CH_U: begin
          esc_phase = PH_HEX0;
          code_acc  = '0;
        end
        default: begin
          seq[0] = CH_BSLASH;
          seq[1] = req.in_byte;
          n = 2;
        end
      endcase
    end else if (esc_phase >= PH_HEX0 && esc_phase <= PH_HEX3) begin
      code_acc = {code_acc[11:0], digit_value(req.in_byte)};
      if (esc_phase != PH_HEX3) begin
        esc_phase = phase_e'(esc_phase + 3'd1);
      end else begin
        cp        = code_acc;
        esc_phase = PH_PLAIN;
        code_acc  = '0;
        if (cp < 16'h0080) begin
          seq[0] = cp[7:0];
          n = 1;
        end else if (cp < 16'h0800) begin
          seq[0] = {3'b110, cp[10:6]};
          seq[1] = {2'b10, cp[5:0]};
          n = 2;
        end else begin
          seq[0] = {4'b1110, cp[15:12]};
          seq[1] = {2'b10, cp[11:6]};
          seq[2] = {2'b10, cp[5:0]};
          n = 3;
        end
      end
    end else begin
      esc_phase = PH_PLAIN;
      if (req.in_byte == CH_BSLASH) begin
        esc_phase = PH_ESC;
      end else begin
        seq[0] = req.in_byte;
        n = 1;
      end
    end
    queue_bytes(seq, n);
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t: result %0d: %s", $realtime, results_seen, msg);
    fail_count++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report_error($sformatf("unexpected result byte %02h valid %0b last %0b end %0b",
                             got.out_byte, got.byte_valid, got.run_last, got.literal_end));
    end else begin
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_error($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report_error($sformatf("byte_valid %0b, want %0b", got.byte_valid, want.byte_valid));
      if (got.run_last !== want.run_last)
        report_error($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
      if (got.literal_end !== want.literal_end)
        report_error($sformatf("literal_end %0b, want %0b", got.literal_end, want.literal_end));
    end
    results_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      esc_phase     = PH_PLAIN;
      code_acc      = '0;
      results_seen  = 0;
      fail_count    = 0;
      pending_count <= 0;
    end else begin
      // Results of a request pass the input and result group registers first.
      if (out_mon.valid && out_mon.ready) begin
        check_result(out_mon.data);
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_request(in_mon.data);
      end
      pending_count <= expected_q.size();
    end
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  // Longest quiet stretch of a correct run is the receiver hold-off below.
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_ITEMS   = 410;

  // Characters that form a one-byte escape after a backslash.
  localparam logic [8:0][7:0] ESC_CHARS = {CH_BSLASH, CH_SLASH, CH_QUOTE, CH_APOS,
                                           CH_B, CH_F, CH_N, CH_R, CH_T};

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   sent;
  int   stall_cycles;
  bit   idle_on;
  bit   hold_req;
  bit   hold_done;
  bit   drain_done;

  jsu_in_if  in_if();
  jsu_out_if out_if();

  json_string_unescape u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  unescape_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request and hold it until the block takes it. Valid stays high
  // into the next request unless an idle burst is drawn.
  task automatic send_req(logic [7:0] b, logic op, logic cl);
    in_item_t req;
    req.in_byte  = b;
    req.is_open  = op;
    req.is_close = cl;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  function automatic bit is_escape_char(logic [7:0] b);
    bit hit;
    hit = (b == CH_U);
    for (int k = 0; k < 9; k++) begin
      if (ESC_CHARS[k] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  // Any byte but a backslash: stays plain text.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] other_escape();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_escape_char(b));
    return b;
  endfunction

  // Hex digit in random case; now and then a non-hex byte that reads as zero.
  function automatic logic [7:0] digit_char(logic [3:0] v);
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) begin
      do c = 8'($urandom_range(0, 255));
      while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66));
    end else if (v < 4'd10) begin
      c = 8'h30 + v;
    end else begin
      c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
    end
    return c;
  endfunction

  // Unicode escape; pick the code point range so that 1, 2 and 3 byte
  // encodings come up evenly.
  task automatic send_unicode();
    logic [15:0] cp;
    case ($urandom_range(0, 2))
      0:       cp = 16'($urandom_range(0, 16'h007F));
      1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
      default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
    send_req(CH_BSLASH, 1'b0, 1'b0);
    send_req(CH_U, 1'b0, 1'b0);
    for (int k = 3; k >= 0; k--) begin
      send_req(digit_char(cp[k*4 +: 4]), 1'b0, 1'b0);
    end
  endtask

  // Cut an escape short with a delimiter: close, open, or both at once.
  task automatic send_broken();
    logic op;
    logic cl;
    send_req(CH_BSLASH, 1'b0, 1'b0);
    if ($urandom_range(0, 1)) begin
      send_req(CH_U, 1'b0, 1'b0);
      repeat ($urandom_range(0, 3)) send_req(digit_char(4'($urandom_range(0, 15))), 1'b0, 1'b0);
    end
    op = 1'($urandom_range(0, 1));
    cl = !op || $urandom_range(0, 1);
    send_req(8'($urandom_range(0, 255)), op, cl);
  endtask

  // One quoted literal with random content; the opening delimiter is
  // sometimes left out so bytes follow a close directly.
  task automatic send_literal();
    int kind;
    if ($urandom_range(0, 9) != 0) send_req(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    repeat ($urandom_range(1, 8)) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send_req(plain_byte(), 1'b0, 1'b0);
      end else if (kind < 55) begin
        send_req(CH_BSLASH, 1'b0, 1'b0);
        send_req(ESC_CHARS[$urandom_range(0, 8)], 1'b0, 1'b0);
      end else if (kind < 75) begin
        send_unicode();
      end else if (kind < 85) begin
        send_req(CH_BSLASH, 1'b0, 1'b0);
        send_req(other_escape(), 1'b0, 1'b0);
      end else begin
        send_broken();
      end
    end
    send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Directed corners: delimiters together, extreme bytes, unknown escape,
  // smallest and largest code points, non-hex digits, escape cut by a close
  // and text right after a close.
  task automatic run_directed();
    send_req(8'h7E, 1'b1, 1'b1);
    send_req(8'h00, 1'b0, 1'b0);
    send_req(8'hFF, 1'b0, 1'b0);
    send_req(CH_BSLASH, 1'b0, 1'b0);
    send_req(8'hFF, 1'b0, 1'b0);
    send_req(CH_BSLASH, 1'b0, 1'b0);
    send_req(CH_U, 1'b0, 1'b0);
    repeat (4) send_req(8'h30, 1'b0, 1'b0);
    send_req(CH_BSLASH, 1'b0, 1'b0);
    send_req(CH_U, 1'b0, 1'b0);
    send_req(8'h46, 1'b0, 1'b0);
    send_req(8'h66, 1'b0, 1'b0);
    send_req(8'h46, 1'b0, 1'b0);
    send_req(8'h66, 1'b0, 1'b0);
    send_req(CH_BSLASH, 1'b0, 1'b0);
    send_req(CH_U, 1'b0, 1'b0);
    send_req(8'h30, 1'b0, 1'b0);
    send_req(8'h37, 1'b0, 1'b0);
    send_req(8'h67, 1'b0, 1'b0);
    send_req(8'h46, 1'b0, 1'b0);
    send_req(CH_BSLASH, 1'b0, 1'b0);
    send_req(CH_QUOTE, 1'b0, 1'b1);
    send_req(8'h5A, 1'b0, 1'b0);
  endtask

  // Receiver: random ready bursts, and one long hold-off on request so the
  // block fills and backs up onto its input.
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Watchdog: end the run if no request and no result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    sent         = 0;
    rst_ni       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    while (sent < NUM_ITEMS) begin
      // Hold off the receiver once while requests keep coming.
      if (!hold_done && sent >= 140) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // Pause the sender once until every expected result is out.
      if (!drain_done && sent >= 260) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending_count != 0) @(posedge clk_i);
        drain_done = 1'b1;
      end
      // Run the tail at full rate on both sides.
      if (sent >= 340) idle_on = 1'b0;
      send_literal();
    end

    // Drop valid, drain, then keep watching for stray results.
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
